FILE: rtl/cpsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cpsg_pkg;

	localparam int SEG_W = 7;

	// floor(floor(2*pi*2^32) / 2^16), so that the segment count is floor(this / angle) + 1.
	localparam logic [18:0] ANGLE_DIVIDEND = 19'd411774;
	localparam logic [18:0] ZERO_ANGLE     = 19'd6554;

	// floor(pi/2 * 2^32) split as HI * 2^17 + LO.
	localparam logic [15:0] HALF_PI_HI = 16'd51471;
	localparam logic [16:0] HALF_PI_LO = 17'd111940;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic             bad;
		logic [SEG_W-1:0] n;
	} q_item_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0: r = 30'd843314857;
			5'd1: r = 30'd497837829;
			5'd2: r = 30'd263043836;
			5'd3: r = 30'd133525159;
			5'd4: r = 30'd67021687;
			5'd5: r = 30'd33543516;
			5'd6: r = 30'd16775851;
			5'd7: r = 30'd8388437;
			5'd8: r = 30'd4194283;
			5'd9: r = 30'd2097149;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// Center in Q8 scaled to Q38 plus radius times trig, truncated toward zero to pixels.
	function automatic logic signed [15:0] to_pixel(input logic signed [23:0] c,
			input logic signed [55:0] prod);
		logic signed [57:0] v;
		logic [57:0]        mag;
		logic [19:0]        p;
		logic signed [15:0] r;
		v   = $signed({{4{c[23]}}, c, 30'b0}) + $signed({{2{prod[55]}}, prod});
		mag = v[57] ? 58'(-v) : 58'(v);
		p   = mag[57:38];
		if (v[57]) begin
			if (p >= 20'd32768) r = -16'sd32768;
			else r = 16'(-$signed({1'b0, p[15:0]}));
		end else begin
			if (p > 20'd32767) r = 16'sd32767;
			else r = $signed(p[15:0]);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/cpsg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cpsg_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] segment_count;
	logic [18:0] step_angle;
	modport source(output valid, req_type, segment_count, step_angle, input ready);
	modport sink(input valid, req_type, segment_count, step_angle, output ready);
endinterface

interface cpsg_seg_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic               last;
	logic               bad_radius;
	modport source(output valid, start_x, start_y, end_x, end_y, last, bad_radius,
		input ready);
	modport sink(input valid, start_x, start_y, end_x, end_y, last, bad_radius,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/cpsg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module cpsg_fifo #(
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  cpsg_pkg::q_item_t wdata,
	input  wire              pop,
	output cpsg_pkg::q_item_t rdata,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cpsg_pkg::q_item_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop && !empty) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CW'(push && !full) - CW'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/cpsg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cpsg_front #(
	parameter int MAX_SEGMENTS = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	cpsg_req_if.sink          req,
	input  wire               radius_zero,
	output logic              push,
	output cpsg_pkg::q_item_t item,
	input  wire               full
);
	typedef enum logic [1:0] {F_IDLE, F_DIV, F_CLAMP, F_PUSH} fstate_t;

	fstate_t       state_q;
	cpsg_pkg::q_item_t item_q;
	logic [19:0]   rem_q;
	logic [18:0]   dvd_q, dvs_q, quo_q;
	logic [4:0]    cnt_q;
	logic [19:0]   trial, qplus;
	logic          fit;
	logic [cpsg_pkg::SEG_W-1:0] cnt_n, ang_n;

	assign req.ready = (state_q == F_IDLE);
	assign push      = (state_q == F_PUSH) && !full;
	assign item      = item_q;

	assign trial = {rem_q[18:0], dvd_q[18]};
	assign fit   = (trial >= {1'b0, dvs_q});
	assign qplus = {1'b0, quo_q} + 20'd1;

	always_comb begin
		if (req.segment_count > 16'(MAX_SEGMENTS)) cnt_n = cpsg_pkg::SEG_W'(MAX_SEGMENTS);
		else if (req.segment_count < 16'd3) cnt_n = cpsg_pkg::SEG_W'(3);
		else cnt_n = req.segment_count[cpsg_pkg::SEG_W-1:0];
		if (qplus > 20'(MAX_SEGMENTS)) ang_n = cpsg_pkg::SEG_W'(MAX_SEGMENTS);
		else if (qplus < 20'd3) ang_n = cpsg_pkg::SEG_W'(3);
		else ang_n = qplus[cpsg_pkg::SEG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			item_q  <= '0;
			rem_q   <= '0;
			dvd_q   <= '0;
			dvs_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (req.valid) begin
						if (radius_zero) begin
							item_q  <= '{bad: 1'b1, n: '0};
							state_q <= F_PUSH;
						end else if (req.req_type) begin
							dvs_q   <= (req.step_angle == '0) ? cpsg_pkg::ZERO_ANGLE
								: req.step_angle;
							dvd_q   <= cpsg_pkg::ANGLE_DIVIDEND;
							rem_q   <= '0;
							quo_q   <= '0;
							cnt_q   <= 5'd19;
							state_q <= F_DIV;
						end else begin
							item_q  <= '{bad: 1'b0, n: cnt_n};
							state_q <= F_PUSH;
						end
					end
				end
				F_DIV: begin
					rem_q <= fit ? trial - {1'b0, dvs_q} : trial;
					quo_q <= {quo_q[17:0], fit};
					dvd_q <= {dvd_q[17:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) state_q <= F_CLAMP;
				end
				F_CLAMP: begin
					item_q  <= '{bad: 1'b0, n: ang_n};
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/cpsg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cpsg_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               empty,
	input  cpsg_pkg::q_item_t item,
	output logic              pop,
	input  wire signed [23:0] center_x,
	input  wire signed [23:0] center_y,
	input  wire        [22:0] radius,
	cpsg_seg_if.source        seg
);
	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int NW = cpsg_pkg::SEG_W;

	typedef enum logic [3:0] {
		B_IDLE, B_DIV, B_MH, B_ML, B_ANG, B_ROT, B_MX, B_MY, B_MP, B_VTX,
		B_EMIT, B_CLOSE, B_BAD
	} bstate_t;

	bstate_t state_q;
	logic [NW-1:0] n_q, k_q;
	logic [7:0]    rem_q;
	logic [31:0]   phase_q;
	logic [5:0]    dcnt_q;
	logic [45:0]   hi_s1;
	logic [46:0]   lo_s1;
	logic signed [33:0] x_q, y_q, z_q;
	logic [IW-1:0] i_q;
	logic signed [55:0] prod_s1;
	logic signed [15:0] px_q, py_q, fx_q, fy_q, prx_q, pry_q;
	logic          ov_q, slot, fire;
	logic [7:0]    trial;
	logic          fit;
	logic [63:0]   theta_sum;
	logic signed [33:0] dx, dy, at, c, s;

	assign trial     = {rem_q[6:0], 1'b0};
	assign fit       = (trial >= {1'b0, n_q});
	assign theta_sum = {hi_s1, 17'b0} + {17'b0, lo_s1};
	assign dx        = y_q >>> i_q;
	assign dy        = x_q >>> i_q;
	assign at        = $signed({4'b0, cpsg_pkg::atan_q30(5'(i_q))});
	assign slot      = !ov_q || seg.ready;
	assign fire      = slot && ((state_q == B_EMIT) || (state_q == B_CLOSE)
		|| (state_q == B_BAD));
	assign pop       = (state_q == B_IDLE) && !empty;
	assign seg.valid = ov_q;

	always_comb begin
		case (phase_q[31:30])
			2'd0: begin c = x_q; s = y_q; end
			2'd1: begin c = -y_q; s = x_q; end
			2'd2: begin c = -x_q; s = -y_q; end
			default: begin c = y_q; s = -x_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
			n_q     <= '0;
			k_q     <= '0;
			rem_q   <= '0;
			phase_q <= '0;
			dcnt_q  <= '0;
			i_q     <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			fx_q    <= '0;
			fy_q    <= '0;
			prx_q   <= '0;
			pry_q   <= '0;
			seg.start_x    <= '0;
			seg.start_y    <= '0;
			seg.end_x      <= '0;
			seg.end_y      <= '0;
			seg.last       <= 1'b0;
			seg.bad_radius <= 1'b0;
		end else begin
			if (fire) ov_q <= 1'b1;
			else if (seg.ready) ov_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						n_q <= item.n;
						if (item.bad) begin
							state_q <= B_BAD;
						end else begin
							k_q     <= '0;
							rem_q   <= '0;
							phase_q <= '0;
							dcnt_q  <= 6'd32;
							state_q <= B_DIV;
						end
					end
				end
				B_DIV: begin
					rem_q   <= fit ? trial - {1'b0, n_q} : trial;
					phase_q <= {phase_q[30:0], fit};
					dcnt_q  <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) state_q <= B_MH;
				end
				B_MH: state_q <= B_ML;
				B_ML: state_q <= B_ANG;
				B_ANG: begin
					x_q     <= cpsg_pkg::CORDIC_GAIN;
					y_q     <= '0;
					z_q     <= $signed({3'b0, theta_sum[62:32]});
					i_q     <= '0;
					state_q <= B_ROT;
				end
				B_ROT: begin
					if (!z_q[33]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					i_q <= i_q + 1'b1;
					if (i_q == IW'(CORDIC_STEPS - 1)) state_q <= B_MX;
				end
				B_MX: state_q <= B_MY;
				B_MY: state_q <= B_MP;
				B_MP: state_q <= B_VTX;
				B_VTX: begin
					if (k_q == '0) begin
						fx_q    <= px_q;
						fy_q    <= py_q;
						prx_q   <= px_q;
						pry_q   <= py_q;
						k_q     <= NW'(1);
						rem_q   <= 8'd1;
						phase_q <= '0;
						dcnt_q  <= 6'd32;
						state_q <= B_DIV;
					end else begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (slot) begin
						seg.start_x    <= prx_q;
						seg.start_y    <= pry_q;
						seg.end_x      <= px_q;
						seg.end_y      <= py_q;
						seg.last       <= 1'b0;
						seg.bad_radius <= 1'b0;
						prx_q          <= px_q;
						pry_q          <= py_q;
						if (k_q == n_q - 1'b1) begin
							state_q <= B_CLOSE;
						end else begin
							k_q     <= k_q + 1'b1;
							rem_q   <= 8'(k_q + 1'b1);
							phase_q <= '0;
							dcnt_q  <= 6'd32;
							state_q <= B_DIV;
						end
					end
				end
				B_CLOSE: begin
					if (slot) begin
						seg.start_x    <= prx_q;
						seg.start_y    <= pry_q;
						seg.end_x      <= fx_q;
						seg.end_y      <= fy_q;
						seg.last       <= 1'b1;
						seg.bad_radius <= 1'b0;
						state_q        <= B_IDLE;
					end
				end
				B_BAD: begin
					if (slot) begin
						seg.start_x    <= '0;
						seg.start_y    <= '0;
						seg.end_x      <= '0;
						seg.end_y      <= '0;
						seg.last       <= 1'b1;
						seg.bad_radius <= 1'b1;
						state_q        <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_MH) hi_s1 <= phase_q[29:0] * cpsg_pkg::HALF_PI_HI;
		if (state_q == B_ML) lo_s1 <= phase_q[29:0] * cpsg_pkg::HALF_PI_LO;
		if (state_q == B_MX) prod_s1 <= $signed({1'b0, radius}) * $signed(c[31:0]);
		if (state_q == B_MY) begin
			px_q    <= cpsg_pkg::to_pixel(center_x, prod_s1);
			prod_s1 <= $signed({1'b0, radius}) * $signed(s[31:0]);
		end
		if (state_q == B_MP) py_q <= cpsg_pkg::to_pixel(center_y, prod_s1);
	end
endmodule
`default_nettype wire

FILE: rtl/circle_polygon_segment_generator_core.sv
// Circle outline drawn as a regular polygon of line segments.
// Requests arrive on the req channel and segments leave on the seg channel, both with a
// valid/ready handshake; an item moves at a clock edge with valid and ready high.
// Center and radius are set by write (index 0 center x, 1 center y, 2 radius);
// the user must write them only while the block is idle; the block does not enforce it.
// A request becomes N segments, N from the count or from floor(2*pi/angle) + 1, clamped to
// [3, MAX_SEGMENTS]; the last one closes back to vertex 0 and has last set.
// A zero radius yields one item with bad_radius and last set.
// The front works out the count by division in angle mode and queues each request two
// deep, so it accepts the next request while the back works, as long as the queue has room.
// The back computes each vertex serially: the phase division, the angle scaling, the
// CORDIC_STEPS rotation steps and the pixel conversion, and then hands each segment
// over to the output register.
// A finished segment waits in the output register; when the receiver stalls, the back
// stops at its next segment until the register empties.
// Reset clears both sides and the queue and loads center 0 and radius 256.
`timescale 1ns / 1ps
`default_nettype none
module circle_polygon_segment_generator_core #(
	parameter int MAX_SEGMENTS = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	cpsg_req_if.sink   req,
	cpsg_seg_if.source seg,
	input  wire        cfg_we,
	input  wire [1:0]  cfg_index,
	input  wire [23:0] cfg_data
);
	localparam logic [1:0] REG_CX = 2'd0;
	localparam logic [1:0] REG_CY = 2'd1;
	localparam logic [1:0] REG_RAD = 2'd2;

	logic signed [23:0] cx_q, cy_q;
	logic [22:0]        rad_q;
	logic               push, pop, full, empty;
	cpsg_pkg::q_item_t  witem, ritem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			rad_q <= 23'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CX: cx_q <= cfg_data;
				REG_CY: cy_q <= cfg_data;
				REG_RAD: rad_q <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	cpsg_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
		.clk, .arst_n, .req, .radius_zero(rad_q == '0), .push, .item(witem), .full
	);

	cpsg_fifo #(.DEPTH(2)) u_fifo (
		.clk, .arst_n, .push, .wdata(witem), .pop, .rdata(ritem), .full, .empty
	);

	cpsg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .empty, .item(ritem), .pop, .center_x(cx_q), .center_y(cy_q),
		.radius(rad_q), .seg
	);

	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		seg.valid && seg.bad_radius |-> seg.last) else $error("bad radius item without last");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !ritem.bad |-> ritem.n >= 7'd3) else $error("segment count below three");
endmodule
`default_nettype wire

FILE: bench/circle_polygon_segment_generator_checker.sv
`timescale 1ns / 1ps
module circle_polygon_segment_generator_checker #(
	parameter int MAX_SEGMENTS = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	cpsg_req_if        req,
	cpsg_seg_if        seg,
	input  wire        cfg_we,
	input  wire [1:0]  cfg_index,
	input  wire [23:0] cfg_data,
	output int         fails,
	output int         pending
);
	localparam logic [1:0] IDX_CENTER_X = 2'd0;
	localparam logic [1:0] IDX_CENTER_Y = 2'd1;
	localparam logic [1:0] IDX_RADIUS   = 2'd2;
	localparam longint unsigned TWO_PI_Q32  = 64'd26986075409;
	localparam longint unsigned HALF_PI_Q32 = 64'd6746518852;
	localparam longint          GAIN_Q30    = 64'sd652032874;

	typedef struct {
		logic signed [15:0] sx, sy, ex, ey;
		logic               last, bad;
	} segment_t;

	longint atan_tbl [24] = '{
		843314857, 497837829, 263043836, 133525159, 67021687, 33543516, 16775851,
		8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048, 1024, 512, 256, 128};

	logic signed [23:0] cx, cy;
	logic        [22:0] rad;
	segment_t           segments_due [$];

	function automatic logic signed [15:0] pixel_of(logic signed [23:0] c, longint trig);
		longint v, mag, p;
		v   = longint'(c) * (64'sd1 << 30) + longint'({1'b0, rad}) * trig;
		mag = v < 0 ? -v : v;
		p   = mag >>> 38;
		if (v < 0) p = -p;
		if (p > 32767) p = 32767;
		if (p < -32768) p = -32768;
		return p[15:0];
	endfunction

	function automatic void vertex_at(int unsigned k, int unsigned n,
			output logic signed [15:0] px, output logic signed [15:0] py);
		longint unsigned phase, rem;
		longint x, y, z, dx, dy, c, s;
		logic [1:0] quad;
		phase = (longint'(k) << 32) / n;
		quad  = phase[31:30];
		rem   = phase & 64'h3FFF_FFFF;
		z     = (rem * HALF_PI_Q32) >> 32;
		x     = GAIN_Q30;
		y     = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tbl[i];
			end else begin
				x += dx; y -= dy; z += atan_tbl[i];
			end
		end
		case (quad)
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		px = pixel_of(cx, c);
		py = pixel_of(cy, s);
	endfunction

	function automatic void predict_polygon(logic t, logic [15:0] cnt, logic [18:0] ang);
		segment_t sg;
		int unsigned n;
		longint unsigned a, q;
		logic signed [15:0] fx, fy, px, py, ex, ey;
		if (rad == 0) begin
			sg = '{0, 0, 0, 0, 1'b1, 1'b1};
			segments_due.push_back(sg);
			return;
		end
		if (t) begin
			a = (ang == 0) ? 64'd6554 : longint'(ang);
			q = TWO_PI_Q32 / (a << 16) + 1;
			n = q > MAX_SEGMENTS ? MAX_SEGMENTS : q;
		end else begin
			n = cnt > MAX_SEGMENTS ? MAX_SEGMENTS : cnt;
		end
		if (n < 3) n = 3;
		vertex_at(0, n, fx, fy);
		px = fx;
		py = fy;
		for (int unsigned k = 0; k < n; k++) begin
			if (k + 1 == n) begin
				ex = fx; ey = fy;
			end else begin
				vertex_at(k + 1, n, ex, ey);
			end
			sg = '{px, py, ex, ey, k + 1 == n, 1'b0};
			segments_due.push_back(sg);
			px = ex;
			py = ey;
		end
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		segment_t w;
		if (!arst_n) begin
			cx <= 0;
			cy <= 0;
			rad <= 23'd256;
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					IDX_CENTER_X: cx <= cfg_data;
					IDX_CENTER_Y: cy <= cfg_data;
					IDX_RADIUS:   rad <= cfg_data[22:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				predict_polygon(req.req_type, req.segment_count, req.step_angle);
			if (seg.valid && seg.ready) begin
				if (segments_due.size() == 0) begin
					$error("segment item arrived with none expected");
					fails++;
				end else begin
					w = segments_due.pop_front();
					check_field("start_x", w.sx, seg.start_x);
					check_field("start_y", w.sy, seg.start_y);
					check_field("end_x", w.ex, seg.end_x);
					check_field("end_y", w.ey, seg.end_y);
					check_field("last", w.last, seg.last);
					check_field("bad_radius", w.bad, seg.bad_radius);
				end
			end
			pending = segments_due.size();
		end
	end
endmodule

FILE: bench/circle_polygon_segment_generator_core_tb.sv
`timescale 1ns / 1ps
module circle_polygon_segment_generator_core_tb;

	localparam logic [1:0] IDX_CENTER_X = 2'd0;
	localparam logic [1:0] IDX_CENTER_Y = 2'd1;
	localparam logic [1:0] IDX_RADIUS   = 2'd2;
	localparam logic [1:0] IDX_UNUSED   = 2'd3;
	localparam int QUIET_LIMIT = 40000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;
	int          fails;
	int          pending;
	int          idle_pct;
	int          stall_pct;
	bit          hold_seg;
	int          quiet;

	cpsg_req_if req ();
	cpsg_seg_if seg ();

	circle_polygon_segment_generator_core uut (
		.clk(clk), .arst_n(arst_n), .req(req), .seg(seg),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

	circle_polygon_segment_generator_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req), .seg(seg),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_seg) seg.ready <= 1'b0;
		else seg.ready <= $urandom_range(99) >= stall_pct;
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (seg.valid && seg.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("FAIL circle_polygon_segment_generator_core");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_polygon(logic t, logic [15:0] cnt, logic [18:0] ang);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= t;
		req.segment_count <= cnt;
		req.step_angle <= ang;
		@(negedge clk);
		while (!req.ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_circle(logic [23:0] x, logic [23:0] y, logic [22:0] r);
		write_reg(IDX_CENTER_X, x);
		write_reg(IDX_CENTER_Y, y);
		write_reg(IDX_RADIUS, {1'b0, r});
	endtask

	task automatic send_random();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) send_polygon(1'b0, 16'($urandom_range(12)), 19'($urandom));
		else if (pick < 50) send_polygon(1'b0, 16'($urandom), 19'($urandom));
		else if (pick < 90) send_polygon(1'b1, 16'($urandom),
			19'($urandom_range(524287, 40000)));
		else send_polygon(1'b1, 16'($urandom), 19'($urandom));
	endtask

	task automatic random_circle();
		case ($urandom_range(3))
			0: set_circle(24'($urandom), 24'($urandom), 23'($urandom));
			1: set_circle(24'($urandom_range(65535)), 24'($urandom_range(65535)),
				23'($urandom_range(40000)));
			2: set_circle(24'h7FFFFF, 24'h800000, 23'h7FFFFF);
			default: set_circle(24'h800000, 24'h7FFFFF, 23'($urandom_range(3000, 1)));
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.segment_count = '0;
		req.step_angle = '0;
		seg.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_seg = 0;
		quiet = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default circle first, then the directed requests.
		send_polygon(1'b0, 16'd0, 19'd0);
		send_polygon(1'b0, 16'd1, 19'h7FFFF);
		send_polygon(1'b0, 16'd2, 19'd0);
		send_polygon(1'b0, 16'd3, 19'd0);
		send_polygon(1'b0, 16'd4, 19'd0);
		send_polygon(1'b0, 16'd64, 19'd0);
		send_polygon(1'b0, 16'd65, 19'd0);
		send_polygon(1'b0, 16'hFFFF, 19'd0);
		send_polygon(1'b1, 16'hFFFF, 19'd0);
		send_polygon(1'b1, 16'd0, 19'd1);
		send_polygon(1'b1, 16'd0, 19'h7FFFF);
		send_polygon(1'b1, 16'd0, 19'd6554);
		send_polygon(1'b1, 16'd0, 19'd102944);
		send_polygon(1'b1, 16'd0, 19'd32768);
		drain();
		set_circle(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF);
		send_polygon(1'b0, 16'd8, 19'd0);
		drain();
		set_circle(24'h800000, 24'h800000, 23'h7FFFFF);
		send_polygon(1'b0, 16'd7, 19'd0);
		drain();
		set_circle(24'h001234, 24'hFFEDCC, 23'd0);
		write_reg(IDX_UNUSED, 24'hFFFFFF);
		send_polygon(1'b0, 16'd5, 19'd0);
		send_polygon(1'b1, 16'd0, 19'd100);
		drain();

		// The receiver holds off while requests keep coming.
		set_circle(24'd5000, 24'hFFF000, 23'd20000);
		fork
			begin
				hold_seg = 1;
				repeat (2000) @(posedge clk);
				hold_seg = 0;
			end
		join_none
		repeat (6) send_polygon(1'b0, 16'($urandom_range(10, 3)), 19'd0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 50; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 50; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				random_circle();
				repeat (27) send_random();
				if ($urandom_range(3) == 0) begin
					drain();
					write_reg(IDX_RADIUS, 24'd0);
					repeat (3) send_random();
					drain();
					write_reg(IDX_RADIUS, 24'($urandom_range(8388607, 1)));
				end
				send_polygon(1'b0, 16'd64, 19'd0);
				drain();
			end
		end

		drain();
		if (fails == 0) $display("PASS circle_polygon_segment_generator_core");
		else $display("FAIL circle_polygon_segment_generator_core");
		$finish;
	end
endmodule
